// File: rtl/mtfe_pkg.sv
// Shared types and constants for the multi-tap feedback echo block.
// No dependencies; used by the controller, datapath, top level and checker.
package mtfe_pkg;

    localparam int SAMPLE_W   = 16;   // audio sample width
    localparam int FRAME_W    = 32;   // stereo word: left in low half
    localparam int LINE_W     = 48;   // stored delay line value, Q16
    localparam int Q_SHIFT    = 16;
    localparam int ROUND_HALF = 32768;

    localparam int GAIN_W     = 17;
    localparam int DELAY_W    = 15;
    localparam int FB_W       = 18;
    localparam int TAPSEL_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [GAIN_W-1:0]    GAIN_RST   = 17'd13107;
    localparam logic [TAPSEL_W-1:0]  TAPS_RST   = 2'd1;
    localparam logic [DELAY_W-1:0]   DELAY0_RST = 15'd9600;
    localparam logic [DELAY_W-1:0]   DELAY1_RST = 15'd1;
    localparam logic signed [FB_W-1:0] FB0_RST  = 18'sd32768;
    localparam logic signed [FB_W-1:0] FB1_RST  = 18'sd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ECHO_GAIN   = 3'd0,
        CFG_TAPS_IN_USE = 3'd1,
        CFG_DELAY_TAP0  = 3'd2,
        CFG_DELAY_TAP1  = 3'd3,
        CFG_FB_TAP0     = 3'd4,
        CFG_FB_TAP1     = 3'd5
    } t_cfg_idx;

    typedef logic [TAPSEL_W-1:0] t_tap;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_E_ABS,
        S_E_HI,
        S_E_LO,
        S_E_SUM,
        S_F_HI,
        S_F_LO,
        S_F_SUM,
        S_WRITE,
        S_O_ADD,
        S_O_SAT
    } t_state;

    typedef struct packed {
        logic load_in;   // latch input word, clear echo sum
        logic acc;       // add current line entry of tap into sum
        logic sum_abs;   // split sum into sign and magnitude
        logic mul_hi;    // upper partial product
        logic mul_lo;    // lower partial product
        logic mul_sum;   // combine partials, round
        logic src_fb;    // multiply is a feedback product
        logic wr;        // write line entry, advance position
        logic out_add;   // dry plus echo
        logic out_load;  // round, saturate, load output word
        t_tap tap;
    } t_cmd;

    typedef struct packed {
        t_tap active;    // taps in use, clamped
        logic out_busy;  // output word held and not taken
    } t_status;

endpackage

// File: rtl/mtfe_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mtfe_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16384,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/mtfe_ctrl.sv
// Sequencer for the echo block: walks taps, multiply halves and output steps.
// Depends on mtfe_pkg for state, command and status types.
module mtfe_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    output logic               o_s_ready,
    input  mtfe_pkg::t_status  i_status,
    output mtfe_pkg::t_cmd     o_cmd
);

    mtfe_pkg::t_state r_state, n_state;
    mtfe_pkg::t_tap   r_tap, n_tap;
    logic             w_last;
    logic             w_none;

    assign w_last = (r_tap + 2'd1) == i_status.active;
    assign w_none = (i_status.active == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtfe_pkg::S_IDLE;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
        end
    end

    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        unique case (r_state)
            mtfe_pkg::S_IDLE: begin
                if (i_s_valid) begin
                    n_tap   = '0;
                    n_state = w_none ? mtfe_pkg::S_E_ABS : mtfe_pkg::S_ACC;
                end
            end
            mtfe_pkg::S_ACC: begin
                if (w_last) begin
                    n_state = mtfe_pkg::S_E_ABS;
                end else begin
                    n_tap = r_tap + 2'd1;
                end
            end
            mtfe_pkg::S_E_ABS: n_state = mtfe_pkg::S_E_HI;
            mtfe_pkg::S_E_HI:  n_state = mtfe_pkg::S_E_LO;
            mtfe_pkg::S_E_LO:  n_state = mtfe_pkg::S_E_SUM;
            mtfe_pkg::S_E_SUM: begin
                n_tap   = '0;
                n_state = w_none ? mtfe_pkg::S_O_ADD : mtfe_pkg::S_F_HI;
            end
            mtfe_pkg::S_F_HI:  n_state = mtfe_pkg::S_F_LO;
            mtfe_pkg::S_F_LO:  n_state = mtfe_pkg::S_F_SUM;
            mtfe_pkg::S_F_SUM: n_state = mtfe_pkg::S_WRITE;
            mtfe_pkg::S_WRITE: begin
                if (w_last) begin
                    n_state = mtfe_pkg::S_O_ADD;
                end else begin
                    n_tap   = r_tap + 2'd1;
                    n_state = mtfe_pkg::S_F_HI;
                end
            end
            mtfe_pkg::S_O_ADD: n_state = mtfe_pkg::S_O_SAT;
            mtfe_pkg::S_O_SAT: begin
                if (!i_status.out_busy) begin
                    n_state = mtfe_pkg::S_IDLE;
                end
            end
            default: n_state = mtfe_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        o_cmd.tap = r_tap;
        o_s_ready = 1'b0;
        unique case (r_state)
            mtfe_pkg::S_IDLE: begin
                o_s_ready     = 1'b1;
                o_cmd.load_in = i_s_valid;
            end
            mtfe_pkg::S_ACC:   o_cmd.acc     = 1'b1;
            mtfe_pkg::S_E_ABS: o_cmd.sum_abs = 1'b1;
            mtfe_pkg::S_E_HI:  o_cmd.mul_hi  = 1'b1;
            mtfe_pkg::S_E_LO:  o_cmd.mul_lo  = 1'b1;
            mtfe_pkg::S_E_SUM: o_cmd.mul_sum = 1'b1;
            mtfe_pkg::S_F_HI: begin
                o_cmd.mul_hi = 1'b1;
                o_cmd.src_fb = 1'b1;
            end
            mtfe_pkg::S_F_LO: begin
                o_cmd.mul_lo = 1'b1;
                o_cmd.src_fb = 1'b1;
            end
            mtfe_pkg::S_F_SUM: begin
                o_cmd.mul_sum = 1'b1;
                o_cmd.src_fb  = 1'b1;
            end
            mtfe_pkg::S_WRITE: o_cmd.wr      = 1'b1;
            mtfe_pkg::S_O_ADD: o_cmd.out_add = 1'b1;
            mtfe_pkg::S_O_SAT: o_cmd.out_load = !i_status.out_busy;
            default: ;
        endcase
    end

endmodule

// File: rtl/mtfe_dp.sv
// Echo datapath: config registers, delay lines, per-channel multiply lanes, output word.
// Depends on mtfe_pkg and mtfe_ram.
module mtfe_dp #(
    parameter int TAPS      = 2,
    parameter int MAX_DELAY = 16384
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [mtfe_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mtfe_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [mtfe_pkg::FRAME_W-1:0]      i_in_data,
    input  mtfe_pkg::t_cmd                    i_cmd,
    output mtfe_pkg::t_status                 o_status,
    output logic                              o_out_valid,
    output logic [mtfe_pkg::FRAME_W-1:0]      o_out_data,
    input  logic                              i_out_ready
);

    // taps_in_use is two bits, so no tap past the third can ever run
    localparam int USED   = (TAPS < 3) ? TAPS : 3;
    localparam int LINE_W = mtfe_pkg::LINE_W;
    localparam int SMP_W  = mtfe_pkg::SAMPLE_W;
    localparam int FB_W   = mtfe_pkg::FB_W;
    localparam int QS     = mtfe_pkg::Q_SHIFT;
    localparam int MAG_W  = LINE_W + $clog2(USED) + 1;
    localparam int LO_W   = 32;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int PL_W   = LO_W + FB_W;
    localparam int PH_W   = HI_W + FB_W;
    localparam int FULL_W = MAG_W + FB_W + 1;
    localparam int V_W    = MAG_W + 2;
    localparam int RW     = V_W - QS;
    localparam int AW     = $clog2(MAX_DELAY);
    localparam int LW     = $clog2(MAX_DELAY + 1);
    localparam int RAM_W  = 2 * LINE_W;

    // configuration registers
    logic [mtfe_pkg::GAIN_W-1:0]    r_gain;
    logic [mtfe_pkg::TAPSEL_W-1:0]  r_taps;
    logic [mtfe_pkg::DELAY_W-1:0]   r_delay0, r_delay1;
    logic signed [FB_W-1:0]         r_fb0, r_fb1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= mtfe_pkg::GAIN_RST;
            r_taps   <= mtfe_pkg::TAPS_RST;
            r_delay0 <= mtfe_pkg::DELAY0_RST;
            r_delay1 <= mtfe_pkg::DELAY1_RST;
            r_fb0    <= mtfe_pkg::FB0_RST;
            r_fb1    <= mtfe_pkg::FB1_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                mtfe_pkg::CFG_ECHO_GAIN:   r_gain   <= i_cfg_data[mtfe_pkg::GAIN_W-1:0];
                mtfe_pkg::CFG_TAPS_IN_USE: r_taps   <= i_cfg_data[mtfe_pkg::TAPSEL_W-1:0];
                mtfe_pkg::CFG_DELAY_TAP0:  r_delay0 <= i_cfg_data[mtfe_pkg::DELAY_W-1:0];
                mtfe_pkg::CFG_DELAY_TAP1:  r_delay1 <= i_cfg_data[mtfe_pkg::DELAY_W-1:0];
                mtfe_pkg::CFG_FB_TAP0:     r_fb0    <= $signed(i_cfg_data);
                mtfe_pkg::CFG_FB_TAP1:     r_fb1    <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_comb begin
        o_status.active = ({30'd0, r_taps} > 32'(TAPS)) ? mtfe_pkg::t_tap'(TAPS) : r_taps;
        o_status.out_busy = o_out_valid && !i_out_ready;
    end

    // per-tap state: position, fill mark, delay line
    logic [AW-1:0]          r_pos  [USED];
    logic [LW-1:0]          r_hwm  [USED];
    logic [RAM_W-1:0]       w_rdata [USED];
    logic                   w_valid [USED];
    logic signed [FB_W-1:0] w_fb    [USED];
    logic [RAM_W-1:0]       w_line_data;

    for (genvar t = 0; t < USED; t++) begin : g_tap
        logic [mtfe_pkg::DELAY_W-1:0] w_delay;
        logic [31:0]                  w_len32;
        logic [LW-1:0]                w_len;
        logic [LW-1:0]                w_p1;
        logic [AW-1:0]                n_pos;
        logic                         w_we;

        if (t == 0) begin : g_cfg0
            assign w_delay = r_delay0;
            assign w_fb[t] = r_fb0;
        end else if (t == 1) begin : g_cfg1
            assign w_delay = r_delay1;
            assign w_fb[t] = r_fb1;
        end else begin : g_fixed
            assign w_delay = mtfe_pkg::DELAY_W'(1);
            assign w_fb[t] = '0;
        end

        // zero acts as one, anything past the line length is clamped
        always_comb begin
            if (w_delay == '0) begin
                w_len32 = 32'd1;
            end else if (32'(w_delay) > 32'(MAX_DELAY)) begin
                w_len32 = 32'(MAX_DELAY);
            end else begin
                w_len32 = 32'(w_delay);
            end
        end
        assign w_len   = w_len32[LW-1:0];
        assign w_p1    = LW'(r_pos[t]) + LW'(1);
        assign n_pos   = (w_p1 >= w_len) ? '0 : w_p1[AW-1:0];
        assign w_we    = i_cmd.wr && (i_cmd.tap == mtfe_pkg::t_tap'(t));
        // entries at or past the fill mark were never written and read as zero
        assign w_valid[t] = LW'(r_pos[t]) < r_hwm[t];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pos[t] <= '0;
                r_hwm[t] <= '0;
            end else if (w_we) begin
                r_pos[t] <= n_pos;
                if (w_p1 > r_hwm[t]) begin
                    r_hwm[t] <= w_p1;
                end
            end
        end

        mtfe_ram #(
            .WIDTH (RAM_W),
            .DEPTH (MAX_DELAY)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (r_pos[t]),
            .i_wdata (w_line_data),
            .i_raddr (r_pos[t]),
            .o_rdata (w_rdata[t])
        );
    end

    // tap selection
    logic [RAM_W-1:0]       w_tap_data;
    logic signed [FB_W-1:0] w_fb_sel;
    logic                   w_fb_neg;
    logic [FB_W-1:0]        w_fb_mag;

    always_comb begin
        w_tap_data = '0;
        w_fb_sel   = '0;
        for (int t = 0; t < USED; t++) begin
            if (i_cmd.tap == mtfe_pkg::t_tap'(t)) begin
                w_fb_sel = w_fb[t];
                if (w_valid[t]) begin
                    w_tap_data = w_rdata[t];
                end
            end
        end
        w_fb_neg = w_fb_sel[FB_W-1];
        w_fb_mag = w_fb_neg ? (~w_fb_sel + 1'b1) : w_fb_sel;
    end

    // two channel lanes
    logic [SMP_W-1:0]        r_dry      [2];
    logic signed [MAG_W-1:0] r_sum      [2];
    logic [MAG_W-1:0]        r_sum_mag  [2];
    logic                    r_echo_neg [2];
    logic [MAG_W-1:0]        r_echo_mag [2];
    logic                    r_fb_neg   [2];
    logic [MAG_W-1:0]        r_fb_mag   [2];
    logic [PL_W-1:0]         r_pp       [2];
    logic [PH_W-1:0]         r_pph      [2];
    logic signed [V_W-1:0]   r_tot      [2];
    logic [SMP_W-1:0]        r_out      [2];
    logic                    r_out_valid;

    logic [MAG_W-1:0]        w_a    [2];
    logic [FB_W-1:0]         w_b;
    logic [LO_W-1:0]         w_mop  [2];
    logic [PL_W-1:0]         w_prod [2];
    logic [FULL_W-1:0]       w_full [2];
    logic [MAG_W-1:0]        w_res  [2];
    logic signed [V_W-1:0]   w_dq   [2];
    logic signed [V_W-1:0]   w_fbv  [2];
    logic signed [V_W-1:0]   w_ev   [2];
    logic signed [V_W-1:0]   w_v    [2];
    logic [LINE_W-1:0]       w_line [2];
    logic signed [V_W-1:0]   w_rsum [2];
    logic [RW-1:0]           w_rnd  [2];
    logic [SMP_W-1:0]        w_sat  [2];

    assign w_b = i_cmd.src_fb ? w_fb_mag : FB_W'(r_gain);

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            w_a[c]    = i_cmd.src_fb ? r_echo_mag[c] : r_sum_mag[c];
            // one 32x18 multiplier per lane, upper half first
            w_mop[c]  = i_cmd.mul_hi ? LO_W'(w_a[c][MAG_W-1:LO_W]) : w_a[c][LO_W-1:0];
            w_prod[c] = w_mop[c] * w_b;
            w_full[c] = FULL_W'({r_pph[c], {LO_W{1'b0}}}) + FULL_W'(r_pp[c])
                      + FULL_W'(mtfe_pkg::ROUND_HALF);
            w_res[c]  = w_full[c][QS +: MAG_W];

            w_dq[c]   = V_W'($signed({r_dry[c], {QS{1'b0}}}));
            w_fbv[c]  = V_W'($signed({1'b0, r_fb_mag[c]}));
            w_ev[c]   = V_W'($signed({1'b0, r_echo_mag[c]}));

            // line value, saturated to the line width
            w_v[c] = r_fb_neg[c] ? (w_dq[c] - w_fbv[c]) : (w_dq[c] + w_fbv[c]);
            if ((w_v[c][V_W-1:LINE_W-1] == '0) || (w_v[c][V_W-1:LINE_W-1] == '1)) begin
                w_line[c] = w_v[c][LINE_W-1:0];
            end else if (w_v[c][V_W-1]) begin
                w_line[c] = {1'b1, {(LINE_W-1){1'b0}}};
            end else begin
                w_line[c] = {1'b0, {(LINE_W-1){1'b1}}};
            end

            // round half away from zero, then saturate to a sample
            w_rsum[c] = r_tot[c] + (r_tot[c][V_W-1] ? V_W'(mtfe_pkg::ROUND_HALF - 1)
                                                    : V_W'(mtfe_pkg::ROUND_HALF));
            w_rnd[c]  = w_rsum[c][V_W-1:QS];
            if ((w_rnd[c][RW-1:SMP_W-1] == '0) || (w_rnd[c][RW-1:SMP_W-1] == '1)) begin
                w_sat[c] = w_rnd[c][SMP_W-1:0];
            end else if (w_rnd[c][RW-1]) begin
                w_sat[c] = {1'b1, {(SMP_W-1){1'b0}}};
            end else begin
                w_sat[c] = {1'b0, {(SMP_W-1){1'b1}}};
            end
        end
    end

    assign w_line_data = {w_line[1], w_line[0]};

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 2; c++) begin
            if (i_cmd.load_in) begin
                r_dry[c] <= i_in_data[c*SMP_W +: SMP_W];
                r_sum[c] <= '0;
            end else if (i_cmd.acc) begin
                r_sum[c] <= r_sum[c] + MAG_W'($signed(w_tap_data[c*LINE_W +: LINE_W]));
            end
            if (i_cmd.sum_abs) begin
                r_echo_neg[c] <= r_sum[c][MAG_W-1];
                r_sum_mag[c]  <= r_sum[c][MAG_W-1] ? (~r_sum[c] + 1'b1) : r_sum[c];
            end
            if (i_cmd.mul_hi) begin
                r_pp[c] <= w_prod[c];
            end
            if (i_cmd.mul_lo) begin
                r_pph[c] <= r_pp[c][PH_W-1:0];
                r_pp[c]  <= w_prod[c];
            end
            if (i_cmd.mul_sum) begin
                if (i_cmd.src_fb) begin
                    r_fb_mag[c] <= w_res[c];
                    r_fb_neg[c] <= r_echo_neg[c] ^ w_fb_neg;
                end else begin
                    r_echo_mag[c] <= w_res[c];
                end
            end
            if (i_cmd.out_add) begin
                r_tot[c] <= r_echo_neg[c] ? (w_dq[c] - w_ev[c]) : (w_dq[c] + w_ev[c]);
            end
            if (i_cmd.out_load) begin
                r_out[c] <= w_sat[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {r_out[1], r_out[0]};

endmodule

// File: rtl/multi_tap_feedback_echo_top.sv
// Multi-tap feedback echo, top level: controller plus datapath; uses mtfe_pkg, mtfe_ctrl,
// mtfe_dp. Each stereo word of signed 16-bit samples is mixed with the gain-scaled sum of
// the active taps' delay line entries, rounded and saturated; each active tap then stores
// the input in Q16 plus its feedback times the echo (saturated to 48 bits) and steps its
// circular position. With A the active tap count (taps_in_use clamped to TAPS, at most
// three), the sequencer reads the A taps one per cycle, takes the sign and magnitude of the
// echo sum, and runs every Q16 product as two halves through one 32x18 multiplier per
// channel (upper half, lower half, then a rounding sum), with a write step after each
// tap's feedback product; the output is formed by adding dry and echo, then rounding,
// saturating and loading the result register.
// A new word is taken only after the previous one is finished; the result waits in an
// output register, and the last step holds if that register is still full. Delay lines
// need no clearing pass: a fill mark per tap makes entries never written read as zero.
// Only min(TAPS, 3) lines are built; a third tap has delay 1 and no feedback.
module multi_tap_feedback_echo_top #(
    parameter int TAPS      = 2,
    parameter int MAX_DELAY = 16384
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [mtfe_pkg::FRAME_W-1:0]     s_axis_tdata,   // in_left, in_right
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [mtfe_pkg::FRAME_W-1:0]     m_axis_tdata,   // out_left, out_right
    input  logic                             i_cfg_wr_en,
    input  logic [mtfe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mtfe_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    mtfe_pkg::t_cmd    w_cmd;
    mtfe_pkg::t_status w_status;

    mtfe_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    mtfe_dp #(
        .TAPS      (TAPS),
        .MAX_DELAY (MAX_DELAY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .i_out_ready (m_axis_tready)
    );

endmodule

// File: rtl/mtfe_checker.sv
// Port-level checks for the echo block, bound to the top level.
// Depends on mtfe_pkg and multi_tap_feedback_echo_top.
module mtfe_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [mtfe_pkg::FRAME_W-1:0] m_axis_tdata
);

    logic w_s_acc;
    assign w_s_acc = s_axis_tvalid && s_axis_tready;

    // reset leaves the block empty and ready for a word
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not idle after reset");

    // a held result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // one word at a time: busy right after acceptance, no result in the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> !s_axis_tready && !$rose(m_axis_tvalid))
        else $error("word accepted while another is in work");

    // a new result appears only as the sequencer returns to idle
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result shown while sequencer busy");

endmodule

bind multi_tap_feedback_echo_top mtfe_checker u_mtfe_checker (.*);
